### design/rvde_pkg.sv
// Package for the RV32I decode/execute block: opcodes, status codes and the
// front-to-back queue entry type. No dependencies.
package rvde_pkg;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
  localparam logic [6:0] F7_ALT = 7'b0100000;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_ILLEGAL = 3'd1, ST_ECALL = 3'd2, ST_EBREAK = 3'd3,
    ST_UNEXP = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    K_ILLEGAL, K_LUI, K_AUIPC, K_JAL, K_JALR, K_BRANCH, K_LOAD, K_STORE,
    K_OPIMM, K_OP, K_ECALL, K_EBREAK, K_LRESP
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;
    logic [31:0] pc;
    logic [31:0] ldata;
  } uop_t;
endpackage

### design/rvde_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on nothing.
interface rvde_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] instruction_word;
  logic [31:0] program_counter;
  logic [31:0] load_data;
  modport source(output valid, operation, instruction_word, program_counter, load_data,
                 input ready);
  modport sink(input valid, operation, instruction_word, program_counter, load_data,
               output ready);
endinterface

interface rvde_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        branch_taken;
  logic        mem_valid;
  logic        mem_write;
  logic [31:0] mem_address;
  logic [1:0]  mem_size;
  logic [31:0] store_data;
  logic        rd_write;
  logic [4:0]  rd_index;
  logic [31:0] rd_value;
  logic [2:0]  status;
  modport source(output valid, next_pc, branch_taken, mem_valid, mem_write, mem_address,
                 mem_size, store_data, rd_write, rd_index, rd_value, status, input ready);
  modport sink(input valid, next_pc, branch_taken, mem_valid, mem_write, mem_address,
               mem_size, store_data, rd_write, rd_index, rd_value, status, output ready);
endinterface

### design/rvde_front.sv
// Front end: classifies each request and pushes it into a two-entry queue.
// Depends on rvde_pkg.
module rvde_front (
  input  logic              clk,
  input  logic              rst_n,
  rvde_in_if.sink           in_ch,
  output logic              q_valid,
  input  logic              q_pop,
  output rvde_pkg::uop_t    q_head
);
  rvde_pkg::uop_t ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_ptr_r, wr_ptr_r;
  logic       push;
  rvde_pkg::kind_t kind;
  logic [6:0] opc, f7;
  logic [2:0] f3;

  assign opc = in_ch.instruction_word[6:0];
  assign f3  = in_ch.instruction_word[14:12];
  assign f7  = in_ch.instruction_word[31:25];

  always_comb begin
    kind = rvde_pkg::K_ILLEGAL;
    if (in_ch.operation) begin
      kind = rvde_pkg::K_LRESP;
    end else begin
      unique case (opc)
        rvde_pkg::OPC_LUI:   kind = rvde_pkg::K_LUI;
        rvde_pkg::OPC_AUIPC: kind = rvde_pkg::K_AUIPC;
        rvde_pkg::OPC_JAL:   kind = rvde_pkg::K_JAL;
        rvde_pkg::OPC_JALR:  if (f3 == 3'd0) kind = rvde_pkg::K_JALR;
        rvde_pkg::OPC_BRANCH: if (f3 != 3'd2 && f3 != 3'd3) kind = rvde_pkg::K_BRANCH;
        rvde_pkg::OPC_LOAD:  if (f3 != 3'd3 && f3 != 3'd6 && f3 != 3'd7)
                               kind = rvde_pkg::K_LOAD;
        rvde_pkg::OPC_STORE: if (f3 <= 3'd2) kind = rvde_pkg::K_STORE;
        rvde_pkg::OPC_OPIMM: begin
          if (f3 == 3'd1) begin
            if (f7 == 7'd0) kind = rvde_pkg::K_OPIMM;
          end else if (f3 == 3'd5) begin
            if (f7 == 7'd0 || f7 == rvde_pkg::F7_ALT) kind = rvde_pkg::K_OPIMM;
          end else begin
            kind = rvde_pkg::K_OPIMM;
          end
        end
        rvde_pkg::OPC_OP: begin
          if (f7 == 7'd0 || (f7 == rvde_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5)))
            kind = rvde_pkg::K_OP;
        end
        rvde_pkg::OPC_SYSTEM: begin
          if (in_ch.instruction_word == rvde_pkg::WORD_ECALL) kind = rvde_pkg::K_ECALL;
          else if (in_ch.instruction_word == rvde_pkg::WORD_EBREAK)
            kind = rvde_pkg::K_EBREAK;
        end
        default: kind = rvde_pkg::K_ILLEGAL;
      endcase
    end
  end

  // A slot frees in the same cycle it is popped, so the queue flows at full rate.
  assign in_ch.ready = (cnt_r != 2'd2) || q_pop;
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head = ent_r[rd_ptr_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= '{kind: kind, word: in_ch.instruction_word,
                           pc: in_ch.program_counter, ldata: in_ch.load_data};
    end
  end
endmodule

### design/rvde_back.sv
// Back end: register file, ALU, branch and memory logic, output register.
// Depends on rvde_pkg.
module rvde_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  rvde_pkg::uop_t q_head,
  rvde_out_if.source     out_ch
);
  logic [31:0] rf_r [32];
  logic [31:0] rf_valid_r;
  logic        lp_r;
  logic [4:0]  pdest_r;
  logic [1:0]  psize_r;
  logic        psigned_r;

  logic [31:0] w, pc, a, b, immi, imms, immb, immj, pc4, r, ld;
  logic [4:0]  rd, rs1, rs2, sh;
  logic [2:0]  f3;
  logic        alt, c;

  logic [31:0] npc; logic taken, mv, mw; logic [31:0] maddr, sdata;
  logic [1:0]  msz; logic wr; logic [4:0] widx; logic [31:0] wval;
  rvde_pkg::status_t st;
  logic set_lp, clr_lp;

  logic        ov_r;
  logic [31:0] npc_r, maddr_r, sdata_r, rdv_r;
  logic        tk_r, mv_r, mw_r, rdw_r;
  logic [1:0]  msz_r;
  logic [4:0]  rdi_r;
  rvde_pkg::status_t st_r;

  assign w = q_head.word;
  assign pc = q_head.pc;
  assign rd = w[11:7];
  assign rs1 = w[19:15];
  assign rs2 = w[24:20];
  assign f3 = w[14:12];
  assign alt = w[30];
  assign a = rf_valid_r[rs1] ? rf_r[rs1] : 32'd0;
  assign b = rf_valid_r[rs2] ? rf_r[rs2] : 32'd0;
  assign immi = {{20{w[31]}}, w[31:20]};
  assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
  assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign pc4 = pc + 32'd4;

  always_comb begin
    logic [31:0] op2;
    op2 = (q_head.kind == rvde_pkg::K_OP) ? b : immi;
    sh = op2[4:0];
    case (f3)
      3'd0: r = (q_head.kind == rvde_pkg::K_OP && alt) ? a - op2 : a + op2;
      3'd1: r = a << sh;
      3'd2: r = {31'd0, $signed(a) < $signed(op2)};
      3'd3: r = {31'd0, a < op2};
      3'd4: r = a ^ op2;
      3'd5: r = alt ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6: r = a | op2;
      default: r = a & op2;
    endcase
    case (f3)
      3'd0: c = a == b;
      3'd1: c = a != b;
      3'd4: c = $signed(a) < $signed(b);
      3'd5: c = !($signed(a) < $signed(b));
      3'd6: c = a < b;
      default: c = a >= b;
    endcase
    case (psize_r)
      2'd0: ld = psigned_r ? {{24{q_head.ldata[7]}}, q_head.ldata[7:0]}
                           : {24'd0, q_head.ldata[7:0]};
      2'd1: ld = psigned_r ? {{16{q_head.ldata[15]}}, q_head.ldata[15:0]}
                           : {16'd0, q_head.ldata[15:0]};
      default: ld = q_head.ldata;
    endcase
  end

  always_comb begin
    npc = pc4; taken = 1'b0; mv = 1'b0; mw = 1'b0; maddr = '0; msz = '0;
    sdata = '0; wr = 1'b0; widx = rd; wval = '0; st = rvde_pkg::ST_OK;
    set_lp = 1'b0; clr_lp = 1'b1;
    unique case (q_head.kind)
      rvde_pkg::K_LUI:   begin wr = 1'b1; wval = {w[31:12], 12'd0}; end
      rvde_pkg::K_AUIPC: begin wr = 1'b1; wval = pc + {w[31:12], 12'd0}; end
      rvde_pkg::K_JAL: begin
        wr = 1'b1; wval = pc4; npc = pc + immj; taken = 1'b1;
      end
      rvde_pkg::K_JALR: begin
        wr = 1'b1; wval = pc4; npc = (a + immi) & 32'hffff_fffe; taken = 1'b1;
      end
      rvde_pkg::K_BRANCH: if (c) begin npc = pc + immb; taken = 1'b1; end
      rvde_pkg::K_LOAD: begin
        mv = 1'b1; maddr = a + immi; msz = f3[1:0]; set_lp = 1'b1;
      end
      rvde_pkg::K_STORE: begin
        mv = 1'b1; mw = 1'b1; maddr = a + imms; msz = f3[1:0];
        case (f3[1:0])
          2'd0: sdata = {24'd0, b[7:0]};
          2'd1: sdata = {16'd0, b[15:0]};
          default: sdata = b;
        endcase
      end
      rvde_pkg::K_OPIMM, rvde_pkg::K_OP: begin wr = 1'b1; wval = r; end
      rvde_pkg::K_ECALL:  st = rvde_pkg::ST_ECALL;
      rvde_pkg::K_EBREAK: st = rvde_pkg::ST_EBREAK;
      rvde_pkg::K_LRESP: begin
        npc = '0;
        if (lp_r) begin wr = 1'b1; widx = pdest_r; wval = ld; end
        else st = rvde_pkg::ST_UNEXP;
      end
      default: st = rvde_pkg::ST_ILLEGAL;
    endcase
    if (widx == 5'd0) wr = 1'b0;
    if (!wr) begin widx = '0; wval = '0; end
  end

  assign q_pop = q_valid && (!ov_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; lp_r <= 1'b0; rf_valid_r <= '0;
      pdest_r <= '0; psize_r <= '0; psigned_r <= 1'b0;
    end else begin
      if (q_pop) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      if (q_pop) begin
        if (set_lp) begin
          lp_r <= 1'b1; pdest_r <= rd; psize_r <= f3[1:0]; psigned_r <= ~f3[2];
        end else if (clr_lp) lp_r <= 1'b0;
        if (wr) rf_valid_r[widx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (wr) rf_r[widx] <= wval;
      npc_r <= npc; tk_r <= taken; mv_r <= mv; mw_r <= mw; maddr_r <= maddr;
      msz_r <= msz; sdata_r <= sdata; rdw_r <= wr; rdi_r <= widx; rdv_r <= wval;
      st_r <= st;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.next_pc = npc_r;
  assign out_ch.branch_taken = tk_r;
  assign out_ch.mem_valid = mv_r;
  assign out_ch.mem_write = mw_r;
  assign out_ch.mem_address = maddr_r;
  assign out_ch.mem_size = msz_r;
  assign out_ch.store_data = sdata_r;
  assign out_ch.rd_write = rdw_r;
  assign out_ch.rd_index = rdi_r;
  assign out_ch.rd_value = rdv_r;
  assign out_ch.status = st_r;
endmodule

### design/rv32i_decode_execute_core.sv
// RV32I decode/execute core: one request in, one result out, in order.
// Requests pass through the queue, then execute into the output register. Throughput
// is one request per cycle unless out_ch stalls, set by the execute stage and regfile port.
// Reset (synchronous, rst_n low) empties the queue and output register, clears
// the pending load and marks every register as zero through per-register valid bits.
// Depends on rvde_pkg, rvde_in_if, rvde_out_if, rvde_front and rvde_back.
module rv32i_decode_execute_core (
  input  logic   clk,
  input  logic   rst_n,
  rvde_in_if.sink    in_ch,
  rvde_out_if.source out_ch
);
  // The front end classifies each request; a two-entry queue decouples it from
  // the back end, which executes against the register file and holds the result
  // in an output register until the consumer takes it.
  logic           q_valid;
  logic           q_pop;
  rvde_pkg::uop_t q_head;

  rvde_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  rvde_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
    .q_head(q_head), .out_ch(out_ch)
  );

  // A result never reports a write to x0.
  a_no_x0: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.rd_write |-> out_ch.rd_index != 5'd0)
    else $error("write to x0 reported");

  // A stalled result holds its status.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
    else $error("stalled result changed");

  // A memory request (load or store) never also reports a register write.
  a_ld: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.mem_valid |-> !out_ch.rd_write)
    else $error("memory request with register write");
endmodule
